### src/ucdep_pkg.sv
package ucdep_pkg;

   // Descriptor type codes
   localparam logic [7:0] DESC_TYPE_INTERFACE = 8'h04;
   localparam logic [7:0] DESC_TYPE_ENDPOINT  = 8'h05;

   // Endpoint attribute transfer types (bmAttributes[1:0])
   localparam logic [1:0] XFER_BULK      = 2'h2;
   localparam logic [1:0] XFER_INTERRUPT = 2'h3;

   // Endpoint address fields
   localparam int unsigned EP_DIR_BIT = 7;

   // Byte offsets within a descriptor
   localparam logic [7:0] OFS_LENGTH    = 8'd0;
   localparam logic [7:0] OFS_TYPE      = 8'd1;
   localparam logic [7:0] OFS_EP_ADDR   = 8'd2;
   localparam logic [7:0] OFS_ATTR_ALT  = 8'd3;
   localparam logic [7:0] OFS_PKT_LO    = 8'd4;
   localparam logic [7:0] OFS_PKT_HI    = 8'd5;

   // Minimum lengths for a descriptor to be used
   localparam logic [7:0] MIN_DESC_LEN  = 8'd2;
   localparam logic [7:0] MIN_IFC_LEN   = 8'd4;
   localparam logic [7:0] MIN_EP_LEN    = 8'd6;

   // Defaults reported for empty slots
   localparam logic [3:0]  DEF_BULK_IN   = 4'd1;
   localparam logic [3:0]  DEF_BULK_OUT  = 4'd2;
   localparam logic [3:0]  DEF_INTERRUPT = 4'd3;
   localparam logic [15:0] DEF_PKT_SIZE  = 16'd64;

endpackage

### src/usb_config_descriptor_endpoint_parser.sv
// Channel   Direction  Ports                                   Item
// req       in         req_valid/req_ready, req_data_byte,     one descriptor byte
//                      req_last_byte
// rsp       out        rsp_valid/rsp_ready, rsp_bulk_in_endpoint, endpoint summary,
//                      rsp_bulk_out_endpoint,                  one per descriptor set
//                      rsp_interrupt_endpoint, rsp_max_packet_size
//
// One byte per cycle while req_ready is high: each accepted byte updates the parser
// registers in the same cycle; the summary for a set appears in the result register
// in the cycle after its last byte is accepted.
// Reset (synchronous, active high) clears the parser and empties the result register.
// A waiting result stalls input only while rsp_ready is low; a result taken in
// the same cycle frees the register for the next set's last byte.
module usb_config_descriptor_endpoint_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_bulk_in_endpoint,
   output logic [3:0]  rsp_bulk_out_endpoint,
   output logic [3:0]  rsp_interrupt_endpoint,
   output logic [15:0] rsp_max_packet_size
);
   import ucdep_pkg::*;

   // Parser state
   logic [7:0]  byte_position_ff, byte_position_in;
   logic [7:0]  desc_length_ff, desc_length_in;
   logic [7:0]  desc_type_ff, desc_type_in;
   logic        parse_stopped_ff, parse_stopped_in;
   logic        ifc_found_ff, ifc_found_in;
   logic [7:0]  alt_setting_ff, alt_setting_in;
   logic [7:0]  ep_address_ff, ep_address_in;
   logic [1:0]  ep_attr_ff, ep_attr_in;
   logic [15:0] ep_pkt_size_ff, ep_pkt_size_in;
   logic [3:0]  found_bulk_in_ff, found_bulk_in_in;
   logic [3:0]  found_bulk_out_ff, found_bulk_out_in;
   logic [3:0]  found_intr_ff, found_intr_in;
   logic [15:0] found_pkt_size_ff, found_pkt_size_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_bulk_in_ff, rsp_bulk_in_in;
   logic [3:0]  rsp_bulk_out_ff, rsp_bulk_out_in;
   logic [3:0]  rsp_intr_ff, rsp_intr_in;
   logic [15:0] rsp_pkt_size_ff, rsp_pkt_size_in;

   logic        req_accept;
   logic [7:0]  pos_inc;
   logic        desc_done;
   logic        ep_is_in;
   logic [3:0]  ep_num;

   // Take a byte whenever the result register is free or being drained
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // Byte walk and descriptor completion
   always_comb begin
      byte_position_in  = byte_position_ff;
      desc_length_in    = desc_length_ff;
      desc_type_in      = desc_type_ff;
      parse_stopped_in  = parse_stopped_ff;
      ifc_found_in      = ifc_found_ff;
      alt_setting_in    = alt_setting_ff;
      ep_address_in     = ep_address_ff;
      ep_attr_in        = ep_attr_ff;
      ep_pkt_size_in    = ep_pkt_size_ff;
      found_bulk_in_in  = found_bulk_in_ff;
      found_bulk_out_in = found_bulk_out_ff;
      found_intr_in     = found_intr_ff;
      found_pkt_size_in = found_pkt_size_ff;
      pos_inc           = byte_position_ff + 8'd1;
      desc_done         = 1'b0;
      ep_is_in          = 1'b0;
      ep_num            = 4'd0;

      if (req_accept && !parse_stopped_ff) begin
         // Latch the field at this offset
         case (byte_position_ff)
            OFS_LENGTH: begin
               desc_length_in = req_data_byte;
               desc_type_in   = 8'd0;
            end
            OFS_TYPE:     desc_type_in  = req_data_byte;
            OFS_EP_ADDR:  ep_address_in = req_data_byte;
            OFS_ATTR_ALT: begin
               alt_setting_in = req_data_byte;
               ep_attr_in     = req_data_byte[1:0];
            end
            OFS_PKT_LO:   ep_pkt_size_in = {8'd0, req_data_byte};
            OFS_PKT_HI:   ep_pkt_size_in = ep_pkt_size_ff | {req_data_byte, 8'd0};
            default: ;
         endcase

         if (byte_position_ff == OFS_LENGTH && req_data_byte == 8'd0) begin
            // Zero length ends parsing for this set
            parse_stopped_in = 1'b1;
         end else begin
            desc_done        = pos_inc >= desc_length_in;
            byte_position_in = desc_done ? 8'd0 : pos_inc;
         end

         // Apply a completed descriptor
         ep_is_in = ep_address_in[EP_DIR_BIT];
         ep_num   = ep_address_in[3:0];
         if (desc_done && desc_length_in >= MIN_DESC_LEN) begin
            if (desc_type_in == DESC_TYPE_INTERFACE && desc_length_in >= MIN_IFC_LEN) begin
               if (!ifc_found_ff && alt_setting_in == 8'd0) begin
                  ifc_found_in = 1'b1;
               end
            end else if (desc_type_in == DESC_TYPE_ENDPOINT &&
                         desc_length_in >= MIN_EP_LEN && ifc_found_ff) begin
               if (ep_attr_in == XFER_BULK) begin
                  if (ep_is_in && found_bulk_in_ff == 4'd0) begin
                     found_bulk_in_in  = ep_num;
                     found_pkt_size_in = ep_pkt_size_in;
                  end else if (!ep_is_in && found_bulk_out_ff == 4'd0) begin
                     found_bulk_out_in = ep_num;
                  end
               end else if (ep_attr_in == XFER_INTERRUPT) begin
                  if (found_intr_ff == 4'd0) begin
                     found_intr_in = ep_num;
                  end
               end
            end
         end
      end
   end

   // Result register load
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_bulk_in_in  = rsp_bulk_in_ff;
      rsp_bulk_out_in = rsp_bulk_out_ff;
      rsp_intr_in     = rsp_intr_ff;
      rsp_pkt_size_in = rsp_pkt_size_ff;
      if (req_accept && req_last_byte) begin
         rsp_valid_in    = 1'b1;
         rsp_bulk_in_in  = (found_bulk_in_in  != 4'd0) ? found_bulk_in_in  : DEF_BULK_IN;
         rsp_bulk_out_in = (found_bulk_out_in != 4'd0) ? found_bulk_out_in : DEF_BULK_OUT;
         rsp_intr_in     = (found_intr_in     != 4'd0) ? found_intr_in     : DEF_INTERRUPT;
         rsp_pkt_size_in = found_pkt_size_in;
      end
   end

   // Parser registers; the last byte of a set clears them for the next
   always_ff @(posedge clock) begin
      if (reset || (req_accept && req_last_byte)) begin
         byte_position_ff  <= 8'd0;
         desc_length_ff    <= 8'd0;
         desc_type_ff      <= 8'd0;
         parse_stopped_ff  <= 1'b0;
         ifc_found_ff      <= 1'b0;
         alt_setting_ff    <= 8'd0;
         ep_address_ff     <= 8'd0;
         ep_attr_ff        <= 2'd0;
         ep_pkt_size_ff    <= 16'd0;
         found_bulk_in_ff  <= 4'd0;
         found_bulk_out_ff <= 4'd0;
         found_intr_ff     <= 4'd0;
         found_pkt_size_ff <= DEF_PKT_SIZE;
      end else begin
         byte_position_ff  <= byte_position_in;
         desc_length_ff    <= desc_length_in;
         desc_type_ff      <= desc_type_in;
         parse_stopped_ff  <= parse_stopped_in;
         ifc_found_ff      <= ifc_found_in;
         alt_setting_ff    <= alt_setting_in;
         ep_address_ff     <= ep_address_in;
         ep_attr_ff        <= ep_attr_in;
         ep_pkt_size_ff    <= ep_pkt_size_in;
         found_bulk_in_ff  <= found_bulk_in_in;
         found_bulk_out_ff <= found_bulk_out_in;
         found_intr_ff     <= found_intr_in;
         found_pkt_size_ff <= found_pkt_size_in;
      end
   end

   // Result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_bulk_in_ff  <= rsp_bulk_in_in;
      rsp_bulk_out_ff <= rsp_bulk_out_in;
      rsp_intr_ff     <= rsp_intr_in;
      rsp_pkt_size_ff <= rsp_pkt_size_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_bulk_in_endpoint   = rsp_bulk_in_ff;
   assign rsp_bulk_out_endpoint  = rsp_bulk_out_ff;
   assign rsp_interrupt_endpoint = rsp_intr_ff;
   assign rsp_max_packet_size    = rsp_pkt_size_ff;

   // A last byte always yields a result next cycle
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_last_byte |=> rsp_valid_ff)
      else $error("last byte accepted without a result");

   // A non-last byte into a free result register yields nothing
   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_last_byte && (!rsp_valid_ff || rsp_ready) |=> !rsp_valid_ff)
      else $error("result without a last byte");

   // The last byte leaves the parser cleared
   a_cleared_after_set: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_last_byte |=>
         byte_position_ff == 8'd0 && !ifc_found_ff && !parse_stopped_ff &&
         found_pkt_size_ff == DEF_PKT_SIZE)
      else $error("parser not cleared after a set");

   // Offset stays inside the current descriptor
   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      byte_position_ff == 8'd0 || byte_position_ff < desc_length_ff)
      else $error("byte offset beyond descriptor length");

   // A stopped parser sits at offset zero
   a_stopped_idle: assert property (@(posedge clock) disable iff (reset)
      parse_stopped_ff |-> byte_position_ff == 8'd0)
      else $error("stopped parser with nonzero offset");

endmodule

### test/tb_usb_config_descriptor_endpoint_parser.sv
module tb_usb_config_descriptor_endpoint_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import ucdep_pkg::*;

   typedef logic [7:0] byte_q_type[$];

   typedef struct packed {
      logic [3:0]  bulk_in;
      logic [3:0]  out_ep;
      logic [3:0]  intr;
      logic [15:0] pkt_size;
   } ep_summary_type;

   // Tracks the parser state byte by byte and holds the endpoint summaries still due
   class endpoint_summary_board;
      logic [7:0]  ofs;
      logic [7:0]  desc_len;
      logic [7:0]  desc_type;
      logic        stopped;
      logic        ifc_seen;
      logic [7:0]  alt;
      logic [7:0]  ep_addr;
      logic [1:0]  ep_attr;
      logic [15:0] pkt_pending;
      logic [3:0]  bulk_in;
      logic [3:0]  out_ep;
      logic [3:0]  intr;
      logic [15:0] pkt_found;
      ep_summary_type expected_q[$];
      int          errors;

      function new();
         errors = 0;
         clear();
      endfunction

      function void clear();
         ofs         = '0;
         desc_len    = '0;
         desc_type   = '0;
         stopped     = 1'b0;
         ifc_seen    = 1'b0;
         alt         = '0;
         ep_addr     = '0;
         ep_attr     = '0;
         pkt_pending = '0;
         bulk_in     = '0;
         out_ep      = '0;
         intr        = '0;
         pkt_found   = DEF_PKT_SIZE;
      endfunction

      // Note one accepted item; the last byte of a set yields a summary
      function void take_byte(logic [7:0] b, logic last);
         ep_summary_type s;
         if (!stopped) begin
            if (ofs == OFS_LENGTH) begin
               desc_len  = b;
               desc_type = '0;
               if (b == 8'd0)
                  stopped = 1'b1;
            end else begin
               case (ofs)
                  OFS_TYPE:     desc_type = b;
                  OFS_EP_ADDR:  ep_addr = b;
                  OFS_ATTR_ALT: begin
                     alt     = b;
                     ep_attr = b[1:0];
                  end
                  OFS_PKT_LO:   pkt_pending = {8'h00, b};
                  OFS_PKT_HI:   pkt_pending[15:8] = b;
                  default: ;
               endcase
            end
            if (!stopped) begin
               ofs = ofs + 8'd1;
               if (ofs >= desc_len) begin
                  // descriptor complete: apply it if long enough
                  if (desc_len >= MIN_DESC_LEN) begin
                     if (desc_type == DESC_TYPE_INTERFACE && desc_len >= MIN_IFC_LEN) begin
                        if (alt == 8'd0)
                           ifc_seen = 1'b1;
                     end else if (desc_type == DESC_TYPE_ENDPOINT && desc_len >= MIN_EP_LEN
                                  && ifc_seen) begin
                        if (ep_attr == XFER_BULK) begin
                           if (ep_addr[EP_DIR_BIT] && bulk_in == 4'd0) begin
                              bulk_in   = ep_addr[3:0];
                              pkt_found = pkt_pending;
                           end else if (!ep_addr[EP_DIR_BIT] && out_ep == 4'd0) begin
                              out_ep = ep_addr[3:0];
                           end
                        end else if (ep_attr == XFER_INTERRUPT && intr == 4'd0) begin
                           intr = ep_addr[3:0];
                        end
                     end
                  end
                  ofs = '0;
               end
            end
         end
         if (last) begin
            s.bulk_in  = (bulk_in  != 4'd0) ? bulk_in  : DEF_BULK_IN;
            s.out_ep   = (out_ep   != 4'd0) ? out_ep   : DEF_BULK_OUT;
            s.intr     = (intr     != 4'd0) ? intr     : DEF_INTERRUPT;
            s.pkt_size = pkt_found;
            expected_q.push_back(s);
            clear();
         end
      endfunction

      // Compare one accepted summary with the oldest one due
      function void check_summary(ep_summary_type got);
         ep_summary_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected summary: in %0d out %0d int %0d size %0d",
                        got.bulk_in, got.out_ep, got.intr, got.pkt_size);
         end else begin
            want = expected_q.pop_front();
            if (got.bulk_in != want.bulk_in || got.out_ep != want.out_ep ||
                got.intr != want.intr || got.pkt_size != want.pkt_size) begin
               errors++;
               if (errors <= 10)
                  $display("summary mismatch: in %0d/%0d out %0d/%0d int %0d/%0d size %0d/%0d",
                           want.bulk_in, got.bulk_in, want.out_ep, got.out_ep,
                           want.intr, got.intr, want.pkt_size, got.pkt_size);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_bulk_in_endpoint;
   logic [3:0]  rsp_bulk_out_endpoint;
   logic [3:0]  rsp_interrupt_endpoint;
   logic [15:0] rsp_max_packet_size;

   endpoint_summary_board board;
   int   send_idle_pct = 27;
   int   rsp_idle_pct = 79;
   int   phase_num = 0;
   int   items_sent = 0;
   logic rsp_hold = 1'b0;

   usb_config_descriptor_endpoint_parser dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_data_byte         (req_data_byte),
      .req_last_byte         (req_last_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_bulk_in_endpoint  (rsp_bulk_in_endpoint),
      .rsp_bulk_out_endpoint (rsp_bulk_out_endpoint),
      .rsp_interrupt_endpoint(rsp_interrupt_endpoint),
      .rsp_max_packet_size   (rsp_max_packet_size)
   );

   always #5 clock = ~clock;

   // Receiver: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset || rsp_hold)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Check every accepted summary
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_summary({rsp_bulk_in_endpoint, rsp_bulk_out_endpoint,
                              rsp_interrupt_endpoint, rsp_max_packet_size});
   end

   // Long receiver hold-off while bytes keep coming, so the input backs up
   initial begin
      wait (phase_num == 2);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (400) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("tb_usb_config_descriptor_endpoint_parser: done, errors");
      $finish;
   end

   // Offer one byte, with an optional gap first; returns once it is accepted
   task automatic send_byte(input logic [7:0] b, input logic last);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      board.take_byte(b, last);
      items_sent++;
   endtask

   task automatic send_set(input byte_q_type set_q);
      foreach (set_q[i])
         send_byte(set_q[i], i == set_q.size() - 1);
   endtask

   // One descriptor set: mostly a well-formed chain with random content
   task automatic send_random_set();
      byte_q_type  set_q;
      int          n_desc;
      int          d_len;
      int          sel;
      int          cut;
      logic [7:0]  d_type;
      logic [7:0]  b2;
      logic [7:0]  b3;
      logic [15:0] pkt;
      set_q = {};
      if ($urandom_range(9) == 0) begin
         // noise
         repeat ($urandom_range(30, 1))
            set_q.push_back(8'($urandom_range(255)));
      end else begin
         n_desc = $urandom_range(7);
         for (int i = 0; i <= n_desc; i++) begin
            d_type = 8'($urandom);
            b2     = 8'($urandom);
            b3     = 8'($urandom);
            pkt    = 16'($urandom);
            if (i == 0)
               sel = 10;
            else if (i == 1 && $urandom_range(9) < 7)
               sel = 0;
            else
               sel = $urandom_range(9);
            case (sel)
               0, 1, 2: begin
                  // interface, usually alternate setting 0
                  d_type = DESC_TYPE_INTERFACE;
                  d_len  = ($urandom_range(9) == 0) ? $urandom_range(5, 1) : 9;
                  if ($urandom_range(2) != 0)
                     b3 = 8'd0;
               end
               3, 4, 5, 6: begin
                  // endpoint, mostly bulk or interrupt
                  d_type = DESC_TYPE_ENDPOINT;
                  d_len  = ($urandom_range(9) == 0) ? $urandom_range(6, 1) : 7;
                  if ($urandom_range(5) == 0)
                     b2[3:0] = 4'd0;
                  if ($urandom_range(3) != 0)
                     b3[1:0] = $urandom_range(1) ? XFER_BULK : XFER_INTERRUPT;
                  case ($urandom_range(4))
                     0: pkt = 16'h0000;
                     1: pkt = 16'hFFFF;
                     2: pkt = 16'd512;
                     default: ;
                  endcase
               end
               7, 8: begin
                  // other type, skipped by length; now and then a long one
                  d_len = ($urandom_range(19) == 0) ? $urandom_range(255, 13)
                                                    : $urandom_range(12, 2);
               end
               9: d_len = 0;
               default: begin
                  // configuration header
                  d_type = 8'h02;
                  d_len  = 9;
               end
            endcase
            set_q.push_back(8'(d_len));
            for (int o = 1; o < d_len; o++) begin
               case (o)
                  1: set_q.push_back(d_type);
                  2: set_q.push_back(b2);
                  3: set_q.push_back(b3);
                  4: set_q.push_back(pkt[7:0]);
                  5: set_q.push_back(pkt[15:8]);
                  default: set_q.push_back(8'($urandom_range(255)));
               endcase
            end
         end
         // broken sequence: end the set partway through
         if ($urandom_range(9) == 0) begin
            cut = $urandom_range(set_q.size() - 1, 1);
            while (set_q.size() > cut)
               void'(set_q.pop_back());
         end
      end
      send_set(set_q);
   endtask

   initial begin
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: length 255 cut off by the end, zero length stop
      send_set('{8'hFF});
      send_set('{8'h00, 8'hA5});
      // length 1, short interface, short endpoint: all ignored
      send_set('{8'h01, 8'h03, 8'h04, 8'h00, 8'h02, 8'h05});
      // bulk IN number 0 with size 0, then interrupt endpoint 15
      send_set('{8'h04, 8'h04, 8'h00, 8'h00,
                 8'h06, 8'h05, 8'h80, 8'h02, 8'h00, 8'h00,
                 8'h06, 8'h05, 8'h0F, 8'hFF, 8'hFF, 8'hFF});

      // random sets over three idling phases
      while (items_sent < 1850) begin
         if (items_sent >= 1240 && phase_num != 2) begin
            phase_num     = 2;
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end else if (items_sent >= 620 && phase_num == 0) begin
            phase_num     = 1;
            send_idle_pct = 79;
            rsp_idle_pct  = 27;
         end
         send_random_set();
      end
      req_valid <= 1'b0;

      while (board.expected_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (board.expected_q.size() != 0) begin
         $display("%0d summaries never arrived", board.expected_q.size());
         board.errors += board.expected_q.size();
      end
      if (board.errors == 0)
         $display("tb_usb_config_descriptor_endpoint_parser: done, clean");
      else
         $display("tb_usb_config_descriptor_endpoint_parser: done, errors");
      $finish;
   end

endmodule

### filelist.f
src/ucdep_pkg.sv
src/usb_config_descriptor_endpoint_parser.sv
test/tb_usb_config_descriptor_endpoint_parser.sv
